[hdl/rif_pkg.sv]
// ============================================================================
// rif_pkg - radix integer formatter package
// Shared widths, ASCII codes, sequencer states and digit helpers.
// ============================================================================
`default_nettype none

package rif_pkg;

    // digit store depth (least significant digits kept if more would arise)
    localparam int MAX_DIGITS = 64;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ND_W    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int BIT_W   = $clog2(VALUE_W);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TOP  = 6'd35;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [VALUE_W-1:0] VALUE_MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VALUE_MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } t_state;

    // clamp the register value to the supported bases
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = ASCII_ZERO;
        if (d <= DIGIT_NINE) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else if (d <= DIGIT_TOP) begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/radix_integer_formatter_unit.sv]
// ============================================================================
// radix_integer_formatter_unit - signed integer to radix text
// Formats a signed 64-bit value as ASCII digits in base 2..36, MSD first.
// ============================================================================
// Steps: the serial divider produces the digits, then a sign character if the
//   value is negative, then each digit is read back from the digit store and
//   emitted through 1 output reg. A new value is taken only when idle, after the
//   last character of the previous one; the restoring divider makes 1 bit per cycle.
// Reset: synchronous, active low; sequencer to idle, radix to 10, no strobe.
// The receiver cannot stall: each character is a single-cycle strobe.
// ============================================================================
`default_nettype none

module radix_integer_formatter_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // radix register write
    input  wire                          i_radix_we,
    input  wire  [rif_pkg::RADIX_W-1:0]  i_radix,
    // command side
    input  wire                          start,
    output logic                         busy,
    input  wire  signed [rif_pkg::VALUE_W-1:0] i_value,
    // character side
    output logic                         o_char_valid,
    output logic [rif_pkg::CHAR_W-1:0]   o_text_char,
    output logic                         o_last_char
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rif_pkg::t_state                r_state, n_state;
    logic [rif_pkg::RADIX_W-1:0]    r_radix;      // raw register value
    logic [rif_pkg::RADIX_W-1:0]    r_base;       // effective base of the item
    logic                           r_neg;
    logic [rif_pkg::VALUE_W-1:0]    r_quot;       // dividend in, quotient out
    logic [rif_pkg::RADIX_W-1:0]    r_rem;        // partial remainder
    logic [rif_pkg::BIT_W-1:0]      r_bit;        // divider step count
    logic [rif_pkg::ND_W-1:0]       r_nd;         // digits stored so far
    logic [rif_pkg::IDX_W-1:0]      r_idx;        // read-back pointer
    logic [rif_pkg::RADIX_W-1:0]    r_rd;         // registered store read
    logic                           r_out_valid;
    logic [rif_pkg::CHAR_W-1:0]     r_out_char;
    logic                           r_out_last;

    // digit store, least significant digit at index 0
    logic [rif_pkg::RADIX_W-1:0]    mem_digit [rif_pkg::MAX_DIGITS];

    // ------------------------------------------------------------------
    // Input conditioning: magnitude with the most negative value clamped
    // ------------------------------------------------------------------
    logic                           s_accept;
    logic                           s_in_neg;
    logic [rif_pkg::VALUE_W-1:0]    s_in_mag;

    assign s_accept = start && (r_state == rif_pkg::ST_IDLE);
    assign s_in_neg = i_value[rif_pkg::VALUE_W-1];

    always_comb begin
        if (!s_in_neg) begin
            s_in_mag = i_value;
        end else if (i_value == rif_pkg::VALUE_MOST_NEG) begin
            s_in_mag = rif_pkg::VALUE_MOST_POS;
        end else begin
            s_in_mag = (~i_value) + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider step: restoring, one quotient bit per cycle.
    // Remainder stays below the base (<= 36) so 7 bits cover the shift.
    // ------------------------------------------------------------------
    logic [rif_pkg::RADIX_W:0]      s_shift;
    logic                           s_ge;
    logic [rif_pkg::RADIX_W-1:0]    s_rem_nxt;
    logic [rif_pkg::VALUE_W-1:0]    s_quot_nxt;
    logic                           s_div_last;
    logic                           s_more;

    assign s_shift    = {r_rem, r_quot[rif_pkg::VALUE_W-1]};
    assign s_ge       = s_shift >= {1'b0, r_base};
    assign s_rem_nxt  = s_ge ? rif_pkg::RADIX_W'(s_shift - {1'b0, r_base})
                             : rif_pkg::RADIX_W'(s_shift);
    assign s_quot_nxt = {r_quot[rif_pkg::VALUE_W-2:0], s_ge};
    assign s_div_last = (r_bit == rif_pkg::BIT_W'(rif_pkg::VALUE_W - 1));
    // another digit is due while the quotient is non-zero and room is left
    assign s_more     = (s_quot_nxt != '0)
                     && (rif_pkg::ND_W'(r_nd + 1'b1) != rif_pkg::ND_W'(rif_pkg::MAX_DIGITS));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rif_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = rif_pkg::ST_DIV;
                end
            end
            rif_pkg::ST_DIV: begin
                if (s_div_last && !s_more) begin
                    n_state = r_neg ? rif_pkg::ST_SIGN : rif_pkg::ST_READ;
                end
            end
            rif_pkg::ST_SIGN: begin
                n_state = rif_pkg::ST_READ;
            end
            rif_pkg::ST_READ: begin
                n_state = rif_pkg::ST_EMIT;
            end
            rif_pkg::ST_EMIT: begin
                n_state = (r_idx == '0) ? rif_pkg::ST_IDLE : rif_pkg::ST_READ;
            end
            default: begin
                n_state = rif_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    logic                           s_mem_we;
    logic                           s_mem_re;
    logic                           s_emit;
    logic [rif_pkg::CHAR_W-1:0]     s_emit_char;
    logic                           s_emit_last;

    always_comb begin
        s_mem_we    = 1'b0;
        s_mem_re    = 1'b0;
        s_emit      = 1'b0;
        s_emit_char = rif_pkg::digit_char(r_rd);
        s_emit_last = 1'b0;
        unique case (r_state)
            rif_pkg::ST_IDLE: begin
            end
            rif_pkg::ST_DIV: begin
                s_mem_we = s_div_last;
            end
            rif_pkg::ST_SIGN: begin
                s_emit      = 1'b1;
                s_emit_char = rif_pkg::ASCII_MINUS;
            end
            rif_pkg::ST_READ: begin
                s_mem_re = 1'b1;
            end
            rif_pkg::ST_EMIT: begin
                s_emit      = 1'b1;
                s_emit_last = (r_idx == '0);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rif_pkg::ST_IDLE;
            r_radix     <= rif_pkg::RADIX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= s_emit;
            if (i_radix_we) begin
                r_radix <= i_radix;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_out_char <= s_emit_char;
        r_out_last <= s_emit_last;
        if (s_accept) begin
            r_base <= rif_pkg::eff_radix(r_radix);
            r_neg  <= s_in_neg;
            r_quot <= s_in_mag;
            r_rem  <= '0;
            r_bit  <= '0;
            r_nd   <= '0;
        end else if (r_state == rif_pkg::ST_DIV) begin
            r_bit <= rif_pkg::BIT_W'(r_bit + 1'b1);
            if (s_div_last) begin
                // quotient becomes the next dividend; remainder restarts
                r_quot <= s_quot_nxt;
                r_rem  <= '0;
                r_nd   <= rif_pkg::ND_W'(r_nd + 1'b1);
                r_idx  <= r_nd[rif_pkg::IDX_W-1:0];
            end else begin
                r_quot <= s_quot_nxt;
                r_rem  <= s_rem_nxt;
            end
        end else if (r_state == rif_pkg::ST_EMIT) begin
            r_idx <= rif_pkg::IDX_W'(r_idx - 1'b1);
        end
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (s_mem_we) begin
            mem_digit[r_nd[rif_pkg::IDX_W-1:0]] <= s_rem_nxt;
        end
        if (s_mem_re) begin
            r_rd <= mem_digit[r_idx];
        end
    end

    assign busy         = (r_state != rif_pkg::ST_IDLE);
    assign o_char_valid = r_out_valid;
    assign o_text_char  = r_out_char;
    assign o_last_char  = r_out_last;

`ifndef ASSERT_OFF
    // a character transfer only follows a sign or digit emit cycle
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == rif_pkg::ST_SIGN
                      || $past(r_state) == rif_pkg::ST_EMIT))
        else $error("character strobe without emit cycle");

    // the last flag never stands without a strobe
    a_last_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> o_char_valid)
        else $error("last flag without character strobe");

    // digit count never passes the store depth while dividing
    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rif_pkg::ST_DIV) |-> (r_nd < rif_pkg::ND_W'(rif_pkg::MAX_DIGITS)))
        else $error("digit store overrun");

    // the working base stays inside 2..36
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rif_pkg::ST_DIV)
            |-> (r_base >= rif_pkg::RADIX_MIN && r_base <= rif_pkg::RADIX_MAX))
        else $error("divider base out of range");

    // an accepted command makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");
`endif

endmodule

`default_nettype wire
